// ----- src/ust_pkg.sv -----
// Shared types, constants and helper functions for the UV sphere tessellator.
// Used by every module under src; it depends on nothing else.
package ust_pkg;

	// Mesh limits and coordinate format.
	localparam int SLICE_MAX  = 256;
	localparam int STACK_MAX  = 256;
	localparam int COORD_BITS = 16;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_W      = 17;
	localparam int VIDX_W     = 16;
	localparam int RING_W     = $clog2(STACK_MAX);
	localparam int COL_W      = $clog2(SLICE_MAX);
	localparam int NUM_W      = RING_W + COL_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SLICE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STACK = 2'd1;
	localparam logic [CFG_W-1:0] SLICE_RESET = 9'd16;
	localparam logic [CFG_W-1:0] STACK_RESET = 9'd8;

	// Request codes.
	localparam logic REQ_VERTEX = 1'b0;

	// Phase division and CORDIC.
	localparam int PHASE_W      = 32;
	localparam int NUMER_W      = PHASE_W + COL_W;
	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 34;
	localparam int MUL_W        = 32;
	localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
	localparam int ROUND_SH     = 60 - (COORD_BITS - 1);

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		KIND_ERR,
		KIND_TOP,
		KIND_BOT,
		KIND_RING,
		KIND_CAP,
		KIND_QUAD
	} kind_t;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] item_index;
	} req_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic [VIDX_W-1:0]            corner_a;
		logic [VIDX_W-1:0]            corner_b;
		logic [VIDX_W-1:0]            corner_c;
		logic                         index_error;
	} rsp_t;

	// One classified item on its way from the front end to the back end.
	typedef struct packed {
		kind_t             kind;
		logic [RING_W-1:0] ring;
		logic [COL_W-1:0]  col;
		logic [VIDX_W-1:0] a;
		logic [VIDX_W-1:0] b;
		logic [VIDX_W-1:0] c;
	} work_t;

	// Arctangent of 2^-i as a fraction of a full turn, rounded to nearest.
	function automatic logic [PHASE_W-1:0] atan_phase(input int i);
		logic [PHASE_W-1:0] p;
		unique case (i)
			0:  p = 32'h20000000;
			1:  p = 32'h12E4051E;
			2:  p = 32'h09FB385B;
			3:  p = 32'h051111D4;
			4:  p = 32'h028B0D43;
			5:  p = 32'h0145D7E1;
			6:  p = 32'h00A2F61E;
			7:  p = 32'h00517C55;
			8:  p = 32'h0028BE53;
			9:  p = 32'h00145F2F;
			10: p = 32'h000A2F98;
			11: p = 32'h000517CC;
			12: p = 32'h00028BE6;
			13: p = 32'h000145F3;
			14: p = 32'h0000A2FA;
			15: p = 32'h0000517D;
			16: p = 32'h000028BE;
			17: p = 32'h0000145F;
			18: p = 32'h00000A30;
			19: p = 32'h00000518;
			20: p = 32'h0000028C;
			21: p = 32'h00000146;
			22: p = 32'h000000A3;
			23: p = 32'h00000051;
			default: p = '0;
		endcase
		return p;
	endfunction

	// One restoring division step: returns {quotient bit, new remainder}.
	// The remainder is always below the divisor, which is at most 256.
	function automatic logic [COL_W:0] div_step(input logic [COL_W-1:0] rem,
		input logic nb, input logic [CFG_W-1:0] d);
		logic [COL_W:0] t;
		logic [COL_W:0] r;
		t = {rem, nb};
		if (t >= d) begin
			r = t - d;
			return {1'b1, r[COL_W-1:0]};
		end
		return {1'b0, t[COL_W-1:0]};
	endfunction

	// Round a Q.60 product half up to the coordinate format and saturate.
	function automatic logic signed [COORD_BITS-1:0] coord_round(
		input logic signed [63:0] v);
		logic signed [63:0] s;
		logic signed [63-ROUND_SH:0] r;
		s = v + (64'sd1 <<< (ROUND_SH - 1));
		r = s[63:ROUND_SH];
		if (r > $signed((64-ROUND_SH)'((1 << (COORD_BITS - 1)) - 1)))
			return {1'b0, {(COORD_BITS-1){1'b1}}};
		if (r < -$signed((64-ROUND_SH)'(1 << (COORD_BITS - 1))))
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		return r[COORD_BITS-1:0];
	endfunction

endpackage

// ----- src/uv_sphere_tessellator.sv -----
// Top level of the UV sphere tessellator: configuration registers, front end,
// queue and back end. Uses ust_pkg, ust_front, ust_queue and ust_back.
//
// Answers one vertex or triangle request per cycle once the pipeline is full
// and out_stall is low. A request passes the front end (an 8-step ring/column
// divider), the queue and the back end, where a 32-step pipelined phase divider
// and a 24-step CORDIC set the depth. The user must write slice and stack
// counts through the configuration port only while no request is in flight;
// the block does not enforce this. Out-of-range values are clamped on use.
module uv_sphere_tessellator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ust_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ust_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ust_pkg::req_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ust_pkg::rsp_t                 out_data
);
	import ust_pkg::*;

	logic [CFG_W-1:0] slice_q, stack_q;
	logic [CFG_W-1:0] slices, stacks;
	logic push, pop, q_full, q_nonempty;
	work_t push_data, pop_data;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= SLICE_RESET;
			stack_q <= STACK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SLICE) begin
				slice_q <= cfg_data;
			end else if (cfg_index == REG_STACK) begin
				stack_q <= cfg_data;
			end
		end
	end

	// Clamped counts used by the datapath.
	always_comb begin
		priority if (slice_q < 9'd3) slices = 9'd3;
		else if (slice_q > CFG_W'(SLICE_MAX)) slices = CFG_W'(SLICE_MAX);
		else slices = slice_q;
		priority if (stack_q < 9'd2) stacks = 9'd2;
		else if (stack_q > CFG_W'(STACK_MAX)) stacks = CFG_W'(STACK_MAX);
		else stacks = stack_q;
	end

	ust_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.slices    (slices),
		.stacks    (stacks),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	ust_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.nonempty  (q_nonempty)
	);

	ust_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (pop_data),
		.pop        (pop),
		.slices     (slices),
		.stacks     (stacks),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ----- src/ust_front.sv -----
// Front end: accepts requests, classifies them, splits the index into ring and
// column with an 8-step pipelined divider and forms triangle corners. Uses ust_pkg.
module ust_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ust_pkg::req_t         in_data,
	input  logic [ust_pkg::CFG_W-1:0] slices,
	input  logic [ust_pkg::CFG_W-1:0] stacks,
	input  logic                  q_full,
	output logic                  push,
	output ust_pkg::work_t        push_data
);
	import ust_pkg::*;

	localparam int DSTEPS = RING_W;

	logic en;
	logic fo_vld_s;
	work_t fo_s;

	// Stage 1: request and vertex count.
	logic v_s1;
	req_t req_s1;
	logic [IDX_W-1:0] nv_s1;
	logic [IDX_W-1:0] nv_c;

	// Division stages carry the classification along.
	logic [DSTEPS:0] dv_vld_s;
	kind_t kind_s [0:DSTEPS];
	logic par_s [0:DSTEPS];
	logic [IDX_W-1:0] nv_s [0:DSTEPS];
	logic [COL_W-1:0] rem_s [0:DSTEPS];
	logic [COL_W-1:0] low_s [0:DSTEPS];
	logic [RING_W-1:0] quo_s [0:DSTEPS];

	kind_t kind_c;
	logic [NUM_W-1:0] num_c;
	logic [IDX_W-1:0] two_s_c;
	logic [IDX_W:0] tri_total_c;

	assign en       = !fo_vld_s || !q_full;
	assign in_stall = !en;
	assign push     = fo_vld_s && !q_full;
	assign push_data = fo_s;

	assign nv_c = IDX_W'({8'd0, slices} * {8'd0, stacks - 9'd1}) + 17'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			dv_vld_s <= '0;
			fo_vld_s <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			dv_vld_s <= {dv_vld_s[DSTEPS-1:0], v_s1};
			fo_vld_s <= dv_vld_s[DSTEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1 <= in_data;
			nv_s1  <= nv_c;
		end
	end

	// Classify the request and pick the dividend.
	always_comb begin
		two_s_c     = IDX_W'({slices, 1'b0});
		tri_total_c = {nv_s1 - 17'd2, 1'b0};
		kind_c      = KIND_ERR;
		num_c       = '0;
		if (req_s1.req_type == REQ_VERTEX) begin
			priority if (req_s1.item_index >= nv_s1) begin
				kind_c = KIND_ERR;
			end else if (req_s1.item_index == '0) begin
				kind_c = KIND_TOP;
			end else if (req_s1.item_index == nv_s1 - 17'd1) begin
				kind_c = KIND_BOT;
			end else begin
				kind_c = KIND_RING;
				num_c  = NUM_W'(req_s1.item_index - 17'd1);
			end
		end else begin
			priority if (req_s1.item_index < two_s_c) begin
				kind_c = KIND_CAP;
				num_c  = NUM_W'(req_s1.item_index >> 1);
			end else if ({1'b0, req_s1.item_index} < tri_total_c) begin
				kind_c = KIND_QUAD;
				num_c  = NUM_W'((req_s1.item_index - two_s_c) >> 1);
			end else begin
				kind_c = KIND_ERR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s[0] <= kind_c;
			par_s[0]  <= req_s1.item_index[0];
			nv_s[0]   <= nv_s1;
			rem_s[0]  <= num_c[NUM_W-1:COL_W];
			low_s[0]  <= num_c[COL_W-1:0];
			quo_s[0]  <= '0;
		end
	end

	// One quotient bit per stage: ring = num / S, column = num % S.
	for (genvar k = 1; k <= DSTEPS; k++) begin : g_div
		logic [COL_W:0] st;
		assign st = div_step(rem_s[k-1], low_s[k-1][COL_W-1], slices);
		always_ff @(posedge clk) begin
			if (en) begin
				kind_s[k] <= kind_s[k-1];
				par_s[k]  <= par_s[k-1];
				nv_s[k]   <= nv_s[k-1];
				rem_s[k]  <= st[COL_W-1:0];
				low_s[k]  <= low_s[k-1] << 1;
				quo_s[k]  <= {quo_s[k-1][RING_W-2:0], st[COL_W]};
			end
		end
	end

	// Triangle corners from ring and column.
	logic [CFG_W-1:0] r1_c, nx_c;
	logic [VIDX_W-1:0] base_c, j0_c, j1_c, rem16_c, nx16_c;
	work_t fo_c;

	always_comb begin
		r1_c    = {1'b0, rem_s[DSTEPS]} + 9'd1;
		nx_c    = (r1_c == slices) ? '0 : r1_c;
		rem16_c = VIDX_W'(rem_s[DSTEPS]);
		nx16_c  = VIDX_W'(nx_c);
		base_c  = VIDX_W'(nv_s[DSTEPS] - 17'd1 - IDX_W'(slices));
		j0_c    = VIDX_W'({8'd0, quo_s[DSTEPS]} * {7'd0, slices}) + 16'd1;
		j1_c    = j0_c + VIDX_W'(slices);
		fo_c.kind = kind_s[DSTEPS];
		fo_c.ring = quo_s[DSTEPS];
		fo_c.col  = rem_s[DSTEPS];
		fo_c.a    = '0;
		fo_c.b    = '0;
		fo_c.c    = '0;
		unique case (kind_s[DSTEPS])
			KIND_CAP: begin
				if (!par_s[DSTEPS]) begin
					fo_c.b = nx16_c + 16'd1;
					fo_c.c = VIDX_W'(r1_c);
				end else begin
					fo_c.a = VIDX_W'(nv_s[DSTEPS] - 17'd1);
					fo_c.b = rem16_c + base_c;
					fo_c.c = nx16_c + base_c;
				end
			end
			KIND_QUAD: begin
				fo_c.a = j0_c + rem16_c;
				if (!par_s[DSTEPS]) begin
					fo_c.b = j0_c + nx16_c;
					fo_c.c = j1_c + nx16_c;
				end else begin
					fo_c.b = j1_c + nx16_c;
					fo_c.c = j1_c + rem16_c;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fo_s <= fo_c;
		end
	end

endmodule

// ----- src/ust_queue.sv -----
// Short queue between the front end and the back end of the tessellator.
// Register storage with read and write pointers; uses ust_pkg.
module ust_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ust_pkg::work_t push_data,
	input  logic           pop,
	output ust_pkg::work_t pop_data,
	output logic           full,
	output logic           nonempty
);
	import ust_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	work_t mem_q [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not rise on a write");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ----- src/ust_back.sv -----
// Back end: phase division, two 24-step CORDIC pipelines, coordinate products
// and the output register. Uses ust_pkg.
module ust_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_nonempty,
	input  ust_pkg::work_t        q_data,
	output logic                  pop,
	input  logic [ust_pkg::CFG_W-1:0] slices,
	input  logic [ust_pkg::CFG_W-1:0] stacks,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ust_pkg::rsp_t         out_data
);
	import ust_pkg::*;

	typedef struct packed {
		kind_t             kind;
		logic [VIDX_W-1:0] a;
		logic [VIDX_W-1:0] b;
		logic [VIDX_W-1:0] c;
	} meta_t;

	logic en;
	logic out_valid_q;
	rsp_t out_q;

	assign en        = !out_valid_q || !out_stall;
	assign pop       = en && q_nonempty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Division stages: phi phase = (ring+1)*2^31/T, theta phase = col*2^32/S.
	logic [PHASE_W:0] dv_vld_s;
	meta_t dv_meta_s [0:PHASE_W];
	logic [COL_W-1:0] prem_s [0:PHASE_W];
	logic [PHASE_W-1:0] plo_s [0:PHASE_W];
	logic [PHASE_W-1:0] pq_s [0:PHASE_W];
	logic [COL_W-1:0] trem_s [0:PHASE_W];
	logic [PHASE_W-1:0] tlo_s [0:PHASE_W];
	logic [PHASE_W-1:0] tq_s [0:PHASE_W];

	// CORDIC stages; stage 0 holds the quadrant-folded start values.
	logic [CORDIC_STEPS:0] cr_vld_s;
	meta_t cr_meta_s [0:CORDIC_STEPS];
	logic fp_s [0:CORDIC_STEPS];
	logic ft_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] px_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] py_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] pz_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] tx_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] ty_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] tz_s [0:CORDIC_STEPS];

	logic ng_vld_s, ml_vld_s;
	meta_t ng_meta_s, ml_meta_s;
	logic signed [MUL_W-1:0] sp_s, cp_s, st_s, ct_s;
	logic signed [63:0] mx_s, my_s, mz_s;

	// Valid bits of the whole back pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s    <= '0;
			cr_vld_s    <= '0;
			ng_vld_s    <= 1'b0;
			ml_vld_s    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			dv_vld_s    <= {dv_vld_s[PHASE_W-1:0], q_nonempty};
			cr_vld_s    <= {cr_vld_s[CORDIC_STEPS-1:0], dv_vld_s[PHASE_W]};
			ng_vld_s    <= cr_vld_s[CORDIC_STEPS];
			ml_vld_s    <= ng_vld_s;
			out_valid_q <= ml_vld_s;
		end
	end

	// Dividends built from the queue head.
	logic [NUMER_W-1:0] np_c, nt_c;
	meta_t qm_c;

	always_comb begin
		np_c = (NUMER_W'({1'b0, q_data.ring} + 9'd1) << (PHASE_W - 1))
			+ NUMER_W'(stacks >> 1);
		nt_c = (NUMER_W'(q_data.col) << PHASE_W) + NUMER_W'(slices >> 1);
		qm_c.kind = q_data.kind;
		qm_c.a    = q_data.a;
		qm_c.b    = q_data.b;
		qm_c.c    = q_data.c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_meta_s[0] <= qm_c;
			prem_s[0]    <= np_c[NUMER_W-1:PHASE_W];
			plo_s[0]     <= np_c[PHASE_W-1:0];
			pq_s[0]      <= '0;
			trem_s[0]    <= nt_c[NUMER_W-1:PHASE_W];
			tlo_s[0]     <= nt_c[PHASE_W-1:0];
			tq_s[0]      <= '0;
		end
	end

	for (genvar k = 1; k <= PHASE_W; k++) begin : g_div
		logic [COL_W:0] ps, ts;
		assign ps = div_step(prem_s[k-1], plo_s[k-1][PHASE_W-1], stacks);
		assign ts = div_step(trem_s[k-1], tlo_s[k-1][PHASE_W-1], slices);
		always_ff @(posedge clk) begin
			if (en) begin
				dv_meta_s[k] <= dv_meta_s[k-1];
				prem_s[k]    <= ps[COL_W-1:0];
				plo_s[k]     <= plo_s[k-1] << 1;
				pq_s[k]      <= {pq_s[k-1][PHASE_W-2:0], ps[COL_W]};
				trem_s[k]    <= ts[COL_W-1:0];
				tlo_s[k]     <= tlo_s[k-1] << 1;
				tq_s[k]      <= {tq_s[k-1][PHASE_W-2:0], ts[COL_W]};
			end
		end
	end

	// Fold phases in [90, 270) degrees by a half turn; the results get negated.
	logic [PHASE_W-1:0] php_c, thp_c, phq_c, thq_c, pp_c, tp_c;
	logic pf_c, tf_c;

	always_comb begin
		php_c = pq_s[PHASE_W];
		thp_c = tq_s[PHASE_W];
		phq_c = php_c + 32'h4000_0000;
		thq_c = thp_c + 32'h4000_0000;
		pf_c  = phq_c[PHASE_W-1];
		tf_c  = thq_c[PHASE_W-1];
		pp_c  = pf_c ? php_c + 32'h8000_0000 : php_c;
		tp_c  = tf_c ? thp_c + 32'h8000_0000 : thp_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_meta_s[0] <= dv_meta_s[PHASE_W];
			fp_s[0]      <= pf_c;
			ft_s[0]      <= tf_c;
			px_s[0]      <= CORDIC_START;
			py_s[0]      <= '0;
			pz_s[0]      <= $signed({{(CW-PHASE_W){pp_c[PHASE_W-1]}}, pp_c});
			tx_s[0]      <= CORDIC_START;
			ty_s[0]      <= '0;
			tz_s[0]      <= $signed({{(CW-PHASE_W){tp_c[PHASE_W-1]}}, tp_c});
		end
	end

	// Rotation-mode CORDIC, one micro-rotation per stage for each angle.
	for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_cordic
		logic signed [CW-1:0] at;
		assign at = $signed({{(CW-PHASE_W){1'b0}}, atan_phase(i - 1)});
		always_ff @(posedge clk) begin
			if (en) begin
				cr_meta_s[i] <= cr_meta_s[i-1];
				fp_s[i]      <= fp_s[i-1];
				ft_s[i]      <= ft_s[i-1];
				if (pz_s[i-1] >= 0) begin
					px_s[i] <= px_s[i-1] - (py_s[i-1] >>> (i - 1));
					py_s[i] <= py_s[i-1] + (px_s[i-1] >>> (i - 1));
					pz_s[i] <= pz_s[i-1] - at;
				end else begin
					px_s[i] <= px_s[i-1] + (py_s[i-1] >>> (i - 1));
					py_s[i] <= py_s[i-1] - (px_s[i-1] >>> (i - 1));
					pz_s[i] <= pz_s[i-1] + at;
				end
				if (tz_s[i-1] >= 0) begin
					tx_s[i] <= tx_s[i-1] - (ty_s[i-1] >>> (i - 1));
					ty_s[i] <= ty_s[i-1] + (tx_s[i-1] >>> (i - 1));
					tz_s[i] <= tz_s[i-1] - at;
				end else begin
					tx_s[i] <= tx_s[i-1] + (ty_s[i-1] >>> (i - 1));
					ty_s[i] <= ty_s[i-1] - (tx_s[i-1] >>> (i - 1));
					tz_s[i] <= tz_s[i-1] + at;
				end
			end
		end
	end

	// Undo the half-turn fold.
	logic signed [CW-1:0] sp_c, cp_c, st_c, ct_c;

	always_comb begin
		sp_c = fp_s[CORDIC_STEPS] ? -py_s[CORDIC_STEPS] : py_s[CORDIC_STEPS];
		cp_c = fp_s[CORDIC_STEPS] ? -px_s[CORDIC_STEPS] : px_s[CORDIC_STEPS];
		st_c = ft_s[CORDIC_STEPS] ? -ty_s[CORDIC_STEPS] : ty_s[CORDIC_STEPS];
		ct_c = ft_s[CORDIC_STEPS] ? -tx_s[CORDIC_STEPS] : tx_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ng_meta_s <= cr_meta_s[CORDIC_STEPS];
			sp_s      <= sp_c[MUL_W-1:0];
			cp_s      <= cp_c[MUL_W-1:0];
			st_s      <= st_c[MUL_W-1:0];
			ct_s      <= ct_c[MUL_W-1:0];
		end
	end

	// Q.60 products.
	always_ff @(posedge clk) begin
		if (en) begin
			ml_meta_s <= ng_meta_s;
			mx_s      <= sp_s * ct_s;
			mz_s      <= sp_s * st_s;
			my_s      <= $signed({{(64-MUL_W-30){cp_s[MUL_W-1]}}, cp_s, 30'd0});
		end
	end

	// Result assembly by kind.
	rsp_t rsp_c;

	always_comb begin
		rsp_c = '0;
		unique case (ml_meta_s.kind)
			KIND_RING: begin
				rsp_c.pos_x = coord_round(mx_s);
				rsp_c.pos_y = coord_round(my_s);
				rsp_c.pos_z = coord_round(mz_s);
			end
			KIND_TOP: begin
				rsp_c.pos_y = {1'b0, {(COORD_BITS-1){1'b1}}};
			end
			KIND_BOT: begin
				rsp_c.pos_y = {1'b1, {(COORD_BITS-1){1'b0}}};
			end
			KIND_CAP, KIND_QUAD: begin
				rsp_c.corner_a = ml_meta_s.a;
				rsp_c.corner_b = ml_meta_s.b;
				rsp_c.corner_c = ml_meta_s.c;
			end
			default: begin
				rsp_c.index_error = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en && ml_vld_s) begin
			out_q <= rsp_c;
		end
	end

endmodule

// ----- test/uv_sphere_tessellator_test.sv -----
// Self-checking testbench for uv_sphere_tessellator: vertex and triangle requests
// are checked against a behavioral mesh predictor over several slice/stack settings.
// Depends on ust_pkg and the RTL under src.
module uv_sphere_tessellator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ust_pkg::*;

	localparam logic REQ_TRIANGLE = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
	localparam int DRAIN_CYCLES = 120;

	// Mesh predictor and store of expected responses.
	class mesh_scoreboard;
		logic [CFG_W-1:0] slices_reg = SLICE_RESET;
		logic [CFG_W-1:0] stacks_reg = STACK_RESET;
		rsp_t expected_rsps[$];
		int errors = 0;
		bit [31:0] turn_table[CORDIC_STEPS] = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
			32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_SLICE) slices_reg = val;
			else if (idx == REG_STACK) stacks_reg = val;
		endfunction

		function longint slices();
			return slices_reg < 3 ? 3 : (slices_reg > SLICE_MAX ? SLICE_MAX : slices_reg);
		endfunction

		function longint stacks();
			return stacks_reg < 2 ? 2 : (stacks_reg > STACK_MAX ? STACK_MAX : stacks_reg);
		endfunction

		function longint vertex_total();
			return slices() * (stacks() - 1) + 2;
		endfunction

		function longint triangle_total();
			return 2 * slices() * (stacks() - 1);
		endfunction

		// Rotation-mode CORDIC on a 32-bit turn phase, Q.30 results.
		function void sin_cos(bit [31:0] phase, output longint sn, output longint cs);
			bit flip;
			bit [31:0] p;
			longint x, y, z, dx, dy;
			flip = ((phase + 32'h40000000) & 32'h80000000) != 0;
			p = flip ? phase + 32'h80000000 : phase;
			z = longint'($signed(p));
			x = 652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(turn_table[i]);
				end else begin
					x += dx; y -= dy; z += longint'(turn_table[i]);
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			sn = y;
			cs = x;
		endfunction

		// Round a Q.60 product half up to Q1.15 and saturate.
		function logic signed [COORD_BITS-1:0] to_coord(longint v);
			longint r;
			r = (v + (longint'(1) <<< 44)) >>> 45;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[COORD_BITS-1:0];
		endfunction

		function rsp_t predict(req_t rq);
			rsp_t rs;
			longint unsigned s, t, nv, idx, m, ring, j, q, pr, i, nx, base, j0, j1;
			bit [31:0] pphi, pth;
			longint sp, cp, st, ct;
			longint unsigned a, b, c;
			rs = '0;
			s = slices();
			t = stacks();
			nv = s * (t - 1) + 2;
			idx = rq.item_index;
			if (rq.req_type == REQ_VERTEX) begin
				if (idx >= nv) rs.index_error = 1'b1;
				else if (idx == 0) rs.pos_y = 16'sh7FFF;
				else if (idx == nv - 1) rs.pos_y = 16'sh8000;
				else begin
					m = idx - 1;
					ring = m / s;
					j = m % s;
					pphi = 32'((((ring + 1) << 31) + t / 2) / t);
					pth = 32'(((j << 32) + s / 2) / s);
					sin_cos(pphi, sp, cp);
					sin_cos(pth, st, ct);
					rs.pos_x = to_coord(sp * ct);
					rs.pos_y = to_coord(cp * (longint'(1) <<< 30));
					rs.pos_z = to_coord(sp * st);
				end
			end else begin
				// Pole fans first, then two triangles per quad.
				if (idx < 2 * s) begin
					i = idx >> 1;
					nx = (i + 1) % s;
					if (idx[0] == 1'b0) begin
						a = 0; b = nx + 1; c = i + 1;
					end else begin
						base = s * (t - 2) + 1;
						a = nv - 1; b = i + base; c = nx + base;
					end
				end else if (idx - 2 * s < 2 * s * (t - 2)) begin
					q = idx - 2 * s;
					pr = q >> 1;
					ring = pr / s;
					i = pr % s;
					nx = (i + 1) % s;
					j0 = ring * s + 1;
					j1 = (ring + 1) * s + 1;
					if (q[0] == 1'b0) begin
						a = j0 + i; b = j0 + nx; c = j1 + nx;
					end else begin
						a = j0 + i; b = j1 + nx; c = j1 + i;
					end
				end else begin
					rs.index_error = 1'b1;
					return rs;
				end
				rs.corner_a = a[15:0];
				rs.corner_b = b[15:0];
				rs.corner_c = c[15:0];
			end
			return rs;
		endfunction

		function void note_request(req_t rq);
			expected_rsps.push_back(predict(rq));
		endfunction

		function void field_check(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_response(rsp_t act);
			rsp_t exp_r;
			if (expected_rsps.size() == 0) begin
				errors++;
				$display("%0t: unexpected response, expected none, actual %h", $time, act);
				return;
			end
			exp_r = expected_rsps.pop_front();
			field_check("pos_x", exp_r.pos_x, act.pos_x);
			field_check("pos_y", exp_r.pos_y, act.pos_y);
			field_check("pos_z", exp_r.pos_z, act.pos_z);
			field_check("corner_a", exp_r.corner_a, act.corner_a);
			field_check("corner_b", exp_r.corner_b, act.corner_b);
			field_check("corner_c", exp_r.corner_c, act.corner_c);
			field_check("index_error", exp_r.index_error, act.index_error);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;
	int cycle_count = 0;
	mesh_scoreboard sb = new();

	uv_sphere_tessellator u_top (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// Long calm stretches with no idling on either side.
	function bit calm();
		return (cycle_count % 3000) < 700;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_stall <= calm() ? 1'b0 : ($urandom_range(99) < 11);
	end

	// Response monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_response(out_data);
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	task automatic send_request(logic kind, int unsigned idx);
		req_t rq;
		rq.req_type = kind;
		rq.item_index = idx[IDX_W-1:0];
		while (!calm() && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= rq;
		do @(posedge clk); while (in_stall);
		sb.note_request(rq);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Random requests: mostly inside the mesh, some at its edge, some anywhere.
	task automatic random_requests(int n);
		logic kind;
		longint total;
		int unsigned idx;
		int r;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(1);
			total = (kind == REQ_VERTEX) ? sb.vertex_total() : sb.triangle_total();
			r = $urandom_range(99);
			if (r < 80) idx = $urandom_range(int'(total) - 1);
			else if (r < 90) idx = int'(total) - 2 + $urandom_range(3);
			else idx = $urandom_range(131071);
			if (idx > 131071) idx = 131071;
			send_request(kind, idx);
		end
	endtask

	initial begin
		longint nv, nt;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: poles, rings, fans, quads, bounds and full-width indexes.
		nv = sb.vertex_total();
		nt = sb.triangle_total();
		send_request(REQ_VERTEX, 0);
		send_request(REQ_VERTEX, 1);
		send_request(REQ_VERTEX, 5);
		send_request(REQ_VERTEX, 17);
		send_request(REQ_VERTEX, int'(nv) - 2);
		send_request(REQ_VERTEX, int'(nv) - 1);
		send_request(REQ_VERTEX, int'(nv));
		send_request(REQ_VERTEX, 131071);
		send_request(REQ_TRIANGLE, 0);
		send_request(REQ_TRIANGLE, 1);
		send_request(REQ_TRIANGLE, 31);
		send_request(REQ_TRIANGLE, 32);
		send_request(REQ_TRIANGLE, 33);
		send_request(REQ_TRIANGLE, int'(nt) - 1);
		send_request(REQ_TRIANGLE, int'(nt));
		send_request(REQ_TRIANGLE, 131071);
		wait_idle();

		// A write to an unused register index must change nothing.
		write_reg(REG_UNUSED, 9'd5);
		random_requests(230);
		wait_idle();

		// Smallest mesh, largest mesh, then out-of-range values that clamp.
		write_reg(REG_SLICE, 9'd3);
		write_reg(REG_STACK, 9'd2);
		random_requests(230);
		wait_idle();
		write_reg(REG_SLICE, 9'd256);
		write_reg(REG_STACK, 9'd256);
		send_request(REQ_TRIANGLE, int'(sb.triangle_total()) - 1);
		send_request(REQ_VERTEX, int'(sb.vertex_total()) - 2);
		random_requests(230);
		wait_idle();
		write_reg(REG_SLICE, 9'd0);
		write_reg(REG_STACK, 9'd1);
		random_requests(200);
		wait_idle();
		write_reg(REG_SLICE, 9'd511);
		write_reg(REG_STACK, 9'd511);
		random_requests(200);
		wait_idle();

		// Random moderate sizes.
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(REG_SLICE, 9'($urandom_range(3, 40)));
			write_reg(REG_STACK, 9'($urandom_range(2, 40)));
			random_requests(210);
			wait_idle();
		end

		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ----- files.f -----
src/ust_pkg.sv
src/ust_front.sv
src/ust_queue.sv
src/ust_back.sv
src/uv_sphere_tessellator.sv
test/uv_sphere_tessellator_test.sv
